>>> rtl/core/assert_macros.svh
// Assertion macros shared by the clustering RTL.
// Needs a clk and an active-low rst_n in the including scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define AST_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication
`define AST_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

>>> rtl/core/hlc_pkg.sv
// Shared constants, types and helpers for the Hamming leader clustering block.
// No dependencies.
package hlc_pkg;

  localparam int MAX_CLUSTERS = 16;
  localparam int VEC_BITS     = 256;
  localparam int COUNT_BITS   = 32;

  localparam int WORD_BITS = 64;
  localparam int VEC_WORDS = 4;
  localparam int CL_W      = (MAX_CLUSTERS > 1) ? $clog2(MAX_CLUSTERS) : 1;
  localparam int OPEN_W    = $clog2(MAX_CLUSTERS + 1);
  localparam int ROW_W     = CL_W + 2;
  localparam int ROWS      = MAX_CLUSTERS * VEC_WORDS;
  localparam int DIST_W    = $clog2(VEC_BITS + 1);
  localparam int POP_W     = 7;
  localparam int CMP_W     = 10;

  localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

  localparam logic [7:0] CFG_THRESH = 8'd0;
  localparam logic [7:0] CFG_LIMIT  = 8'd1;

  localparam logic [1:0] PL_MATCH = 2'd0;
  localparam logic [1:0] PL_NEW   = 2'd1;
  localparam logic [1:0] PL_FULL  = 2'd2;

  typedef enum logic [2:0] {
    ST_IDLE, ST_SCAN, ST_DECIDE, ST_UPD, ST_JOIN, ST_FLUSH, ST_DONE
  } state_t;

  typedef struct packed {
    logic             rd;
    logic [ROW_W-1:0] row;
    logic             clr;
  } cnt_req_t;

  typedef struct packed {
    logic                 we;
    logic [ROW_W-1:0]     row;
    logic [WORD_BITS-1:0] word;
  } cen_wr_t;

  function automatic logic [WORD_BITS-1:0] word_mask(int w);
    int lo;
    logic [WORD_BITS-1:0] m;
    lo = w * WORD_BITS;
    if (lo >= VEC_BITS) m = '0;
    else if (VEC_BITS - lo >= WORD_BITS) m = '1;
    else m = (WORD_BITS'(1) << (VEC_BITS - lo)) - WORD_BITS'(1);
    return m;
  endfunction

  localparam logic [WORD_BITS-1:0] WMASK [VEC_WORDS] =
    '{word_mask(0), word_mask(1), word_mask(2), word_mask(3)};

  function automatic logic [POP_W-1:0] popcount64(logic [WORD_BITS-1:0] x);
    logic [POP_W-1:0] n;
    n = '0;
    for (int i = 0; i < WORD_BITS; i++) n = n + POP_W'(x[i]);
    return n;
  endfunction

endpackage

>>> rtl/core/hlc_cnt_bank.sv
// Per-bit counter store: one row of 64 counters per cluster and hash word,
// row valid bits for fast clear, lane update and centroid bit vote. Uses hlc_pkg.
module hlc_cnt_bank import hlc_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  cnt_req_t              req,
  input  logic [WORD_BITS-1:0]  vword,
  input  logic [COUNT_BITS-1:0] half,
  output cen_wr_t               cwr
);

  logic [WORD_BITS*COUNT_BITS-1:0] mem [ROWS];
  logic [WORD_BITS*COUNT_BITS-1:0] rd_r;
  logic [WORD_BITS*COUNT_BITS-1:0] new_row;
  logic [ROWS-1:0]                 valid_r;
  logic                            rdv_r;
  logic                            pend_r;
  logic [ROW_W-1:0]                row_r;
  logic [WORD_BITS-1:0]            vw_r;
  logic [WORD_BITS-1:0]            vote;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
      pend_r  <= 1'b0;
    end else begin
      pend_r <= req.rd;
      if (req.clr) begin
        valid_r <= '0;
      end else if (pend_r) begin
        valid_r[row_r] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.rd) begin
      rd_r  <= mem[req.row];
      rdv_r <= valid_r[req.row];
      row_r <= req.row;
      vw_r  <= vword;
    end
    if (pend_r) begin
      mem[row_r] <= new_row;
    end
  end

  always_comb begin
    logic [COUNT_BITS-1:0] c;
    for (int i = 0; i < WORD_BITS; i++) begin
      c = rdv_r ? rd_r[i*COUNT_BITS +: COUNT_BITS] : '0;
      c = c + COUNT_BITS'(vw_r[i]);
      new_row[i*COUNT_BITS +: COUNT_BITS] = c;
      vote[i] = c > half;
    end
  end

  assign cwr.we   = pend_r;
  assign cwr.row  = row_r;
  assign cwr.word = vote;

endmodule

>>> rtl/core/hamming_leader_clustering.sv
// Top level of the Hamming leader clustering block: sequencer, centroid store,
// shared popcount unit. Uses hlc_pkg, hlc_cnt_bank and assert_macros.svh.
//
//  channel | dir | handshake           | payload
//  in_     | in  | in_valid / in_stall | start_new, item_tag, vec_word0..3
//  out_    | out | out_valid/out_stall | tag_out, cluster_id, placement, member_count
//  cfg_    | in  | cfg_we              | cfg_index, cfg_wdata
//
// For each request the shared popcount unit handles one 64-bit centroid word per
// cycle over the N clusters scanned (1 to 16; N is 0 with none open), then four
// counter rows are read, updated and written back, one row per cycle. A saturated
// cluster skips the counter update.
// start_new clears all clusters at once through the counter row valid bits.
// Reset is synchronous; in_stall is high while a request is in work.
// A finished result waits in the output register while the next request runs.
`include "assert_macros.svh"
module hamming_leader_clustering import hlc_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_start_new,
  input  logic [31:0] in_item_tag,
  input  logic [63:0] in_vec_word0,
  input  logic [63:0] in_vec_word1,
  input  logic [63:0] in_vec_word2,
  input  logic [63:0] in_vec_word3,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] out_tag_out,
  output logic [3:0]  out_cluster_id,
  output logic [1:0]  out_placement,
  output logic [31:0] out_member_count,
  input  logic        cfg_we,
  input  logic [7:0]  cfg_index,
  input  logic [8:0]  cfg_wdata
);

  localparam int IW = ROW_W + 1;

  state_t state_r, state_nxt;

  logic [8:0]            thr_r;
  logic [4:0]            lim_r;
  logic [31:0]           tag_r;
  logic [WORD_BITS-1:0]  vec_r [VEC_WORDS];
  logic [COUNT_BITS-1:0] members_r [MAX_CLUSTERS];
  logic [OPEN_W-1:0]     open_r;
  logic [WORD_BITS-1:0]  cen_mem [ROWS];
  logic [WORD_BITS-1:0]  cen_rd_r;

  logic [IW-1:0]         iss_r;
  logic                  ra_v_r, rb_v_r;
  logic [1:0]            ra_w_r, rb_w_r;
  logic [CL_W-1:0]       ra_c_r, rb_c_r;
  logic [POP_W-1:0]      pop_r;
  logic [DIST_W-1:0]     acc_r;
  logic [CMP_W-1:0]      best_d_r;
  logic [CL_W-1:0]       best_r, chosen_r;
  logic                  found_r;
  logic [1:0]            place_r;
  logic [2:0]            jw_r;
  logic [COUNT_BITS-1:0] half_r;

  logic                  out_valid_r;
  logic [31:0]           out_tag_r, out_cnt_r;
  logic [3:0]            out_cid_r;
  logic [1:0]            out_pl_r;

  logic                  accept, issue, scan_done, match, last_c, sat;
  logic [DIST_W-1:0]     ham_d;
  logic [1:0]            vidx;
  logic [WORD_BITS-1:0]  vsel;
  logic [7:0]            lim8;
  logic [COUNT_BITS-1:0] m_cur;
  cnt_req_t              creq;
  cen_wr_t               cwr;

  assign in_stall  = (state_r != ST_IDLE);
  assign accept    = in_valid && !in_stall;
  assign ham_d     = acc_r + DIST_W'(pop_r);
  assign match     = CMP_W'(ham_d) <= CMP_W'(thr_r);
  assign last_c    = (OPEN_W'(rb_c_r) + OPEN_W'(1)) == open_r;
  assign scan_done = (state_r == ST_SCAN) &&
                     ((open_r == '0) || (rb_v_r && rb_w_r == 2'd3 && (match || last_c)));
  assign issue     = (state_r == ST_SCAN) && !scan_done &&
                     (iss_r < IW'({open_r, 2'b00}));
  assign vidx      = (state_r == ST_SCAN) ? ra_w_r : jw_r[1:0];
  assign vsel      = vec_r[vidx];
  assign m_cur     = members_r[chosen_r];
  assign sat       = (m_cur == COUNT_MAX);
  assign lim8      = (lim_r == 5'd0) ? 8'd1 :
                     ((8'(lim_r) > 8'(MAX_CLUSTERS)) ? 8'(MAX_CLUSTERS) : 8'(lim_r));

  assign creq.rd  = (state_r == ST_JOIN);
  assign creq.row = {chosen_r, jw_r[1:0]};
  assign creq.clr = accept && in_start_new;

  hlc_cnt_bank u_cnt (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (creq),
    .vword (vsel),
    .half  (half_r),
    .cwr   (cwr)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= ST_IDLE;
    else        state_r <= state_nxt;
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE:   if (in_valid) state_nxt = ST_SCAN;
      ST_SCAN:   if (scan_done) state_nxt = ST_DECIDE;
      ST_DECIDE: state_nxt = ST_UPD;
      ST_UPD:    state_nxt = sat ? ST_DONE : ST_JOIN;
      ST_JOIN:   if (jw_r == 3'd3) state_nxt = ST_FLUSH;
      ST_FLUSH:  state_nxt = ST_DONE;
      ST_DONE:   if (!out_valid_r || !out_stall) state_nxt = ST_IDLE;
      default:   state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r       <= 9'd128;
      lim_r       <= 5'd16;
      open_r      <= '0;
      out_valid_r <= 1'b0;
      ra_v_r      <= 1'b0;
      rb_v_r      <= 1'b0;
      found_r     <= 1'b0;
      iss_r       <= '0;
      jw_r        <= '0;
      for (int i = 0; i < MAX_CLUSTERS; i++) members_r[i] <= '0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_THRESH: thr_r <= cfg_wdata;
          CFG_LIMIT:  lim_r <= cfg_wdata[4:0];
          default:    ;
        endcase
      end
      ra_v_r <= issue;
      rb_v_r <= ra_v_r && !scan_done;
      if (state_r == ST_DONE && (!out_valid_r || !out_stall)) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        ST_IDLE: begin
          if (in_valid) begin
            iss_r   <= '0;
            found_r <= 1'b0;
            if (in_start_new) begin
              open_r <= '0;
              for (int i = 0; i < MAX_CLUSTERS; i++) members_r[i] <= '0;
            end
          end
        end
        ST_SCAN: begin
          if (issue) iss_r <= iss_r + IW'(1);
          if (rb_v_r && rb_w_r == 2'd3 && match) found_r <= 1'b1;
        end
        ST_DECIDE: begin
          if (!found_r && 8'(open_r) < lim8) open_r <= open_r + OPEN_W'(1);
        end
        ST_UPD: begin
          jw_r <= '0;
          if (!sat) members_r[chosen_r] <= m_cur + COUNT_BITS'(1);
        end
        ST_JOIN: jw_r <= jw_r + 3'd1;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      tag_r    <= in_item_tag;
      vec_r[0] <= in_vec_word0 & WMASK[0];
      vec_r[1] <= in_vec_word1 & WMASK[1];
      vec_r[2] <= in_vec_word2 & WMASK[2];
      vec_r[3] <= in_vec_word3 & WMASK[3];
      acc_r    <= '0;
      best_d_r <= '1;
      best_r   <= '0;
    end
    if (issue) begin
      cen_rd_r <= cen_mem[iss_r[ROW_W-1:0]];
      ra_w_r   <= iss_r[1:0];
      ra_c_r   <= iss_r[ROW_W-1:2];
    end
    if (cwr.we) cen_mem[cwr.row] <= cwr.word;
    pop_r  <= popcount64((cen_rd_r ^ vsel) & WMASK[ra_w_r]);
    rb_w_r <= ra_w_r;
    rb_c_r <= ra_c_r;
    if (state_r == ST_SCAN && rb_v_r) begin
      if (rb_w_r == 2'd3) begin
        acc_r <= '0;
        if (match) begin
          chosen_r <= rb_c_r;
        end else if (CMP_W'(ham_d) < best_d_r) begin
          best_d_r <= CMP_W'(ham_d);
          best_r   <= rb_c_r;
        end
      end else begin
        acc_r <= ham_d;
      end
    end
    if (state_r == ST_DECIDE) begin
      if (found_r) begin
        place_r <= PL_MATCH;
      end else if (8'(open_r) < lim8) begin
        chosen_r <= open_r[CL_W-1:0];
        place_r  <= PL_NEW;
      end else begin
        chosen_r <= best_r;
        place_r  <= PL_FULL;
      end
    end
    if (state_r == ST_UPD) half_r <= (m_cur + COUNT_BITS'(1)) >> 1;
    if (state_r == ST_DONE && (!out_valid_r || !out_stall)) begin
      out_tag_r <= tag_r;
      out_cid_r <= 4'(chosen_r);
      out_pl_r  <= place_r;
      out_cnt_r <= 32'(m_cur);
    end
  end

  assign out_valid        = out_valid_r;
  assign out_tag_out      = out_tag_r;
  assign out_cluster_id   = out_cid_r;
  assign out_placement    = out_pl_r;
  assign out_member_count = out_cnt_r;

  `AST_IMP(a_open_max, 1'b1, open_r <= OPEN_W'(MAX_CLUSTERS))
  `AST_NXT(a_busy_after_req, accept, in_stall)
  `AST_IMP(a_join_nonempty, state_r == ST_JOIN, members_r[chosen_r] != '0)
  `AST_IMP(a_place_code, out_valid, out_placement != 2'd3)

endmodule

>>> dv/hlc_checker.sv
// Checker for the Hamming leader clustering block: watches the request and
// result channels, predicts each result and compares it. Uses hlc_pkg.
`timescale 1ns / 100ps
module hlc_checker import hlc_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic        in_start_new,
  input  logic [31:0] in_item_tag,
  input  logic [63:0] in_vec_word0,
  input  logic [63:0] in_vec_word1,
  input  logic [63:0] in_vec_word2,
  input  logic [63:0] in_vec_word3,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic [31:0] out_tag_out,
  input  logic [3:0]  out_cluster_id,
  input  logic [1:0]  out_placement,
  input  logic [31:0] out_member_count,
  input  logic        cfg_we,
  input  logic [7:0]  cfg_index,
  input  logic [8:0]  cfg_wdata,
  output int          fail_count,
  output int          pending
);

  typedef struct packed {
    logic [31:0] tag;
    logic [3:0]  cid;
    logic [1:0]  place;
    logic [31:0] members;
  } placement_t;

  logic [8:0]  thresh;
  logic [4:0]  limit_reg;
  logic [31:0] bit_cnt [MAX_CLUSTERS][VEC_BITS];
  logic [VEC_BITS-1:0] centroid [MAX_CLUSTERS];
  logic [31:0] members [MAX_CLUSTERS];
  int          n_open;
  placement_t  placements_due [$];

  function automatic void clear_all();
    for (int c = 0; c < MAX_CLUSTERS; c++) begin
      members[c] = '0;
      centroid[c] = '0;
      for (int b = 0; b < VEC_BITS; b++) bit_cnt[c][b] = '0;
    end
    n_open = 0;
  endfunction

  function automatic placement_t place_vector(logic clr, logic [31:0] tag,
                                              logic [VEC_BITS-1:0] v);
    placement_t r;
    int lim, best, best_d, d, pick;
    logic [1:0] pl;
    logic hit;
    if (clr) clear_all();
    lim = limit_reg;
    if (lim < 1) lim = 1;
    if (lim > MAX_CLUSTERS) lim = MAX_CLUSTERS;
    best = 0;
    best_d = 1 << 30;
    hit = 0;
    pick = 0;
    pl = PL_FULL;
    for (int c = 0; c < n_open && !hit; c++) begin
      d = $countones(centroid[c] ^ v);
      if (d <= thresh) begin
        hit = 1;
        pick = c;
        pl = PL_MATCH;
      end else if (d < best_d) begin
        best_d = d;
        best = c;
      end
    end
    if (!hit) begin
      if (n_open < lim) begin
        pick = n_open;
        n_open++;
        pl = PL_NEW;
      end else pick = best;
    end
    if (members[pick] != COUNT_MAX) begin
      members[pick] = members[pick] + 1;
      for (int b = 0; b < VEC_BITS; b++) begin
        if (v[b]) bit_cnt[pick][b] = bit_cnt[pick][b] + 1;
        centroid[pick][b] = bit_cnt[pick][b] > (members[pick] >> 1);
      end
    end
    r.tag = tag;
    r.cid = 4'(pick);
    r.place = pl;
    r.members = members[pick];
    return r;
  endfunction

  assign pending = placements_due.size();

  always @(posedge clk) begin
    placement_t e;
    int errs;
    errs = 0;
    if (!rst_n) begin
      thresh <= 9'd128;
      limit_reg <= 5'd16;
      clear_all();
      placements_due.delete();
      fail_count <= 0;
    end else begin
      if (cfg_we) begin
        if (cfg_index == CFG_THRESH) thresh <= cfg_wdata;
        else if (cfg_index == CFG_LIMIT) limit_reg <= cfg_wdata[4:0];
      end
      if (in_valid && !in_stall)
        placements_due = {placements_due, place_vector(in_start_new, in_item_tag,
          {in_vec_word3, in_vec_word2, in_vec_word1, in_vec_word0})};
      if (out_valid && !out_stall) begin
        if (placements_due.size() == 0) begin
          $error("unexpected result tag %0h", out_tag_out);
          errs++;
        end else begin
          e = placements_due.pop_front();
          if (e.tag !== out_tag_out) begin
            $error("tag_out exp %0h got %0h", e.tag, out_tag_out);
            errs++;
          end
          if (e.cid !== out_cluster_id) begin
            $error("cluster_id exp %0d got %0d", e.cid, out_cluster_id);
            errs++;
          end
          if (e.place !== out_placement) begin
            $error("placement exp %0d got %0d", e.place, out_placement);
            errs++;
          end
          if (e.members !== out_member_count) begin
            $error("member_count exp %0d got %0d", e.members, out_member_count);
            errs++;
          end
        end
      end
      fail_count <= fail_count + errs;
    end
  end

endmodule

>>> dv/tb_hamming_leader_clustering.sv
// Testbench top for the Hamming leader clustering block: clock, reset,
// request stimulus, config phases and verdict. Uses hlc_pkg and hlc_checker.
`timescale 1ns / 100ps
module tb_hamming_leader_clustering;
  import hlc_pkg::*;

  logic        clk, rst_n;
  logic        in_valid, in_stall, in_start_new;
  logic [31:0] in_item_tag;
  logic [63:0] in_vec_word0, in_vec_word1, in_vec_word2, in_vec_word3;
  logic        out_valid, out_stall;
  logic [31:0] out_tag_out, out_member_count;
  logic [3:0]  out_cluster_id;
  logic [1:0]  out_placement;
  logic        cfg_we;
  logic [7:0]  cfg_index;
  logic [8:0]  cfg_wdata;
  int          fail_count, pending;
  int          tag_seq;
  logic [VEC_BITS-1:0] seeds [4];
  int          stall_mode;

  hamming_leader_clustering i_dut (.*);
  hlc_checker i_chk (.*);

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  initial begin
    #100ms;
    $display("TB_ERROR");
    $finish;
  end

  always @(posedge clk) begin
    if (!rst_n) stall_mode <= 0;
    else if ($urandom_range(0, 99) == 0) stall_mode <= $urandom_range(0, 3);
    case (stall_mode)
      0: out_stall <= 1'b0;
      1: out_stall <= ($urandom_range(0, 3) == 0);
      2: out_stall <= ($urandom_range(0, 1) == 0);
      default: out_stall <= ($urandom_range(0, 9) != 0);
    endcase
  end

  function automatic logic [VEC_BITS-1:0] rand_vec();
    logic [VEC_BITS-1:0] v;
    for (int i = 0; i < 8; i++) v[i*32 +: 32] = $urandom;
    return v;
  endfunction

  // copy of a seed with flips randomly chosen bit positions toggled (a position may repeat)
  function automatic logic [VEC_BITS-1:0] near_vec(logic [VEC_BITS-1:0] s, int flips);
    for (int i = 0; i < flips; i++) s[$urandom_range(0, VEC_BITS-1)] ^= 1'b1;
    return s;
  endfunction

  task automatic send(logic clr, logic [VEC_BITS-1:0] v);
    in_valid <= 1'b1;
    in_start_new <= clr;
    in_item_tag <= tag_seq;
    {in_vec_word3, in_vec_word2, in_vec_word1, in_vec_word0} <= v;
    tag_seq = $urandom;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic idle(int n);
    in_valid <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  task automatic drain();
    idle(1);
    while (pending != 0) @(posedge clk);
    repeat (80) @(posedge clk);
  endtask

  task automatic write_reg(logic [7:0] idx, logic [8:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic random_phase(int n);
    int burst;
    for (int k = 0; k < 4; k++) seeds[k] = rand_vec();
    while (n > 0) begin
      burst = $urandom_range(1, 20);
      for (int j = 0; j < burst && n > 0; j++, n--) begin
        case ($urandom_range(0, 9))
          0: send(1'b1, near_vec(seeds[$urandom_range(0, 3)], $urandom_range(0, 40)));
          1, 2: send(1'b0, rand_vec());
          3: send(1'b0, ~seeds[$urandom_range(0, 3)]);
          default: send(1'b0, near_vec(seeds[$urandom_range(0, 3)],
                                       $urandom_range(0, 150)));
        endcase
      end
      if ($urandom_range(0, 2) != 0) idle($urandom_range(0, 30));
    end
  endtask

  initial begin
    rst_n = 0;
    in_valid = 0;
    in_start_new = 0;
    in_item_tag = 0;
    {in_vec_word3, in_vec_word2, in_vec_word1, in_vec_word0} = '0;
    cfg_we = 0;
    cfg_index = CFG_THRESH;
    cfg_wdata = 0;
    tag_seq = 0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send(1'b0, '0);
    send(1'b0, '1);
    tag_seq = 32'hFFFF_FFFF;
    send(1'b0, '1);
    send(1'b1, {64'hFFFF_FFFF_FFFF_FFFF, 64'h0, 64'hAAAA_AAAA_AAAA_AAAA, 64'h0});
    drain();
    write_reg(CFG_THRESH, 9'd0);
    write_reg(CFG_LIMIT, 5'd0);
    send(1'b1, '0);
    send(1'b0, '1);
    send(1'b0, '1);
    send(1'b0, {128'h0, {128{1'b1}}});
    drain();
    write_reg(CFG_THRESH, 9'd256);
    write_reg(CFG_LIMIT, 5'd31);
    send(1'b1, '1);
    send(1'b0, '0);
    drain();
    write_reg(CFG_THRESH, 9'd511);
    write_reg(CFG_LIMIT, 5'd16);
    send(1'b0, rand_vec());
    drain();
    write_reg(CFG_THRESH, 9'd0);
    for (int i = 0; i < 18; i++) send(1'b0, rand_vec());
    drain();

    write_reg(CFG_THRESH, 9'd128);
    write_reg(CFG_LIMIT, 5'd16);
    random_phase(450);
    drain();
    write_reg(CFG_THRESH, 9'd90);
    write_reg(CFG_LIMIT, 5'd4);
    random_phase(450);
    drain();
    write_reg(CFG_THRESH, 9'd30);
    write_reg(CFG_LIMIT, 5'd1);
    random_phase(300);
    drain();
    write_reg(CFG_THRESH, 9'd60);
    write_reg(CFG_LIMIT, 5'd16);
    random_phase(620);
    drain();

    if (fail_count == 0) $display("TB_OK");
    else $display("TB_ERROR");
    $finish;
  end

endmodule

>>> filelist.f
+incdir+rtl/core
rtl/core/hlc_pkg.sv
rtl/core/hlc_cnt_bank.sv
rtl/core/hamming_leader_clustering.sv
dv/hlc_checker.sv
dv/tb_hamming_leader_clustering.sv
